### hdl/ep2c_pkg.sv
// ----------------------------------------------------------------------------
// ep2c_pkg: shared types and constants for the epoch seconds converter
// Field widths, constant reciprocals for the divisions, the month start
// table and the structures passed between the front, queue and back end.
// ----------------------------------------------------------------------------
package ep2c_pkg;

    // Port field widths
    localparam int SECS_W   = 32;
    localparam int MICRO_W  = 20;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DOM_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 64;

    // Internal widths
    localparam int X_W      = 25;   // seconds with the low seven bits removed
    localparam int LOW_W    = 7;    // 86400 and 31536000 are both 128 * odd
    localparam int PROD_W   = 51;   // 25 x 26 bit reciprocal products
    localparam int DAYS_W   = 16;
    localparam int REM_W    = 17;   // seconds within the day
    localparam int K_W      = 8;    // whole 365-day years since the epoch
    localparam int DN_W     = 11;   // signed first estimate of the day of year
    localparam int DOY_W    = 9;
    localparam int HPROD_W  = 26;
    localparam int HX_W     = 13;   // seconds of day divided by 16
    localparam int HR_W     = 9;
    localparam int REM2_W   = 12;   // seconds within the hour
    localparam int MPROD_W  = 20;
    localparam int MX_W     = 10;   // seconds of hour divided by 4
    localparam int MR_W     = 5;

    // Division of seconds by 86400 is a division of seconds/128 by 675
    localparam int DAY_DIV   = 675;
    localparam int DAY_SHIFT = 35;
    localparam logic [25:0] DAY_RECIP = 26'((64'd1 << DAY_SHIFT) / DAY_DIV);

    // Division of seconds by 31536000 is a division of seconds/128 by 246375
    localparam int YEAR_DIV   = 246375;
    localparam int YEAR_SHIFT = 43;
    localparam logic [25:0] YEAR_RECIP = 26'((64'd1 << YEAR_SHIFT) / YEAR_DIV);

    // Seconds of day by 3600 is seconds/16 by 225
    localparam int HOUR_DIV   = 225;
    localparam int HOUR_SHIFT = 20;
    localparam logic [12:0] HOUR_RECIP = 13'((64'd1 << HOUR_SHIFT) / HOUR_DIV);

    // Seconds of hour by 60 is seconds/4 by 15
    localparam int MIN_DIV   = 15;
    localparam int MIN_SHIFT = 14;
    localparam logic [10:0] MIN_RECIP = 11'((64'd1 << MIN_SHIFT) / MIN_DIV);

    localparam int BASE_YEAR       = 1970;
    localparam int LEAP_BASE_YEAR  = 1969;
    localparam int DAYS_PER_YEAR   = 365;
    localparam int SKIPPED_LEAP_YR = 2100;

    localparam int MONTHS = 12;

    localparam int FIFO_DEPTH_DEFAULT = 4;

    // Item passed from the front end through the queue
    typedef struct packed {
        logic [DN_W-1:0]    dn0;
        logic [K_W-1:0]     k;
        logic [HPROD_W-1:0] h_prod;
        logic [REM_W-1:0]   rem_day;
        logic [MICRO_W-1:0] micro;
    } split_t;

    // Finished result
    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DOM_W-1:0]    dom;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [MICRO_W-1:0]  micro;
    } result_t;

    // Queue status seen by both ends, and the requests that drive the queue
    typedef struct packed {
        logic can_push;
        logic can_pop;
    } q_stat_t;

    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    // Day of year at which each month starts, non-leap year, zero based
    function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] idx);
        logic [DOY_W-1:0] val;
        unique case (idx)
            4'd0:    val = 9'd0;
            4'd1:    val = 9'd31;
            4'd2:    val = 9'd59;
            4'd3:    val = 9'd90;
            4'd4:    val = 9'd120;
            4'd5:    val = 9'd151;
            4'd6:    val = 9'd181;
            4'd7:    val = 9'd212;
            4'd8:    val = 9'd243;
            4'd9:    val = 9'd273;
            4'd10:   val = 9'd304;
            4'd11:   val = 9'd334;
            default: val = 9'd0;
        endcase
        return val;
    endfunction

endpackage

### hdl/ep2c_front.sv
// ----------------------------------------------------------------------------
// ep2c_front: splits the seconds count
// Three stages: reciprocal products, corrected day and year quotients, then
// the hour product and the first day-of-year estimate.
// ----------------------------------------------------------------------------
module ep2c_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ep2c_pkg::SECS_W-1:0]   secs_in,
    input  logic [ep2c_pkg::MICRO_W-1:0]  micro_in,
    input  ep2c_pkg::q_stat_t             q_stat,
    output logic                          push,
    output ep2c_pkg::split_t              item
);

    logic f1_v_reg, f2_v_reg, f3_v_reg;
    logic en1, en2, en3;

    logic [ep2c_pkg::X_W-1:0]     x_reg;
    logic [ep2c_pkg::LOW_W-1:0]   low_reg;
    logic [ep2c_pkg::PROD_W-1:0]  day_prod_reg, day_prod_next;
    logic [ep2c_pkg::PROD_W-1:0]  yr_prod_reg, yr_prod_next;
    logic [ep2c_pkg::MICRO_W-1:0] micro1_reg, micro2_reg;

    logic [ep2c_pkg::DAYS_W-1:0]  days_reg, days_next;
    logic [ep2c_pkg::REM_W-1:0]   rem_day_reg, rem_day_next;
    logic [ep2c_pkg::K_W-1:0]     k_reg, k_next;

    ep2c_pkg::split_t             item_reg, item_next;

    logic [ep2c_pkg::DAYS_W-1:0]  day_q;
    logic [ep2c_pkg::X_W-1:0]     day_r;
    logic [9:0]                   day_rem;
    logic [ep2c_pkg::K_W-1:0]     yr_q;
    logic [ep2c_pkg::X_W-1:0]     yr_r;
    logic [17:0]                  dn_wide;
    logic [5:0]                   leaps0;

    assign en3     = !f3_v_reg || q_stat.can_push;
    assign en2     = !f2_v_reg || en3;
    assign en1     = !f1_v_reg || en2;
    assign s_ready = en1;
    assign push    = f3_v_reg && q_stat.can_push;
    assign item    = item_reg;

    // Stage 1: multiply by the reciprocals
    always_comb begin
        day_prod_next = ep2c_pkg::PROD_W'(secs_in[ep2c_pkg::SECS_W-1:ep2c_pkg::LOW_W])
                      * ep2c_pkg::PROD_W'(ep2c_pkg::DAY_RECIP);
        yr_prod_next  = ep2c_pkg::PROD_W'(secs_in[ep2c_pkg::SECS_W-1:ep2c_pkg::LOW_W])
                      * ep2c_pkg::PROD_W'(ep2c_pkg::YEAR_RECIP);
    end

    // Stage 2: the estimates are low by at most one, fix with one compare
    always_comb begin
        day_q = day_prod_reg[ep2c_pkg::DAY_SHIFT +: ep2c_pkg::DAYS_W];
        day_r = x_reg - ep2c_pkg::X_W'(day_q) * ep2c_pkg::X_W'(ep2c_pkg::DAY_DIV);
        if (day_r >= ep2c_pkg::X_W'(ep2c_pkg::DAY_DIV)) begin
            days_next = day_q + 16'd1;
            day_rem   = 10'(day_r - ep2c_pkg::X_W'(ep2c_pkg::DAY_DIV));
        end else begin
            days_next = day_q;
            day_rem   = 10'(day_r);
        end
        rem_day_next = {day_rem, low_reg};

        yr_q = yr_prod_reg[ep2c_pkg::YEAR_SHIFT +: ep2c_pkg::K_W];
        yr_r = x_reg - ep2c_pkg::X_W'(yr_q) * ep2c_pkg::X_W'(ep2c_pkg::YEAR_DIV);
        if (yr_r >= ep2c_pkg::X_W'(ep2c_pkg::YEAR_DIV)) begin
            k_next = yr_q + 8'd1;
        end else begin
            k_next = yr_q;
        end
    end

    // Stage 3: hour product and day of year for the estimated year.
    // The estimate is never below 1 - 34, so the signed value fits easily.
    always_comb begin
        leaps0  = 6'((9'(k_reg) + 9'd1) >> 2);
        dn_wide = 18'(days_reg) + 18'd1
                - 18'(k_reg) * 18'(ep2c_pkg::DAYS_PER_YEAR)
                - 18'(leaps0);
        item_next.dn0     = dn_wide[ep2c_pkg::DN_W-1:0];
        item_next.k       = k_reg;
        item_next.h_prod  = ep2c_pkg::HPROD_W'(rem_day_reg[ep2c_pkg::REM_W-1:4])
                          * ep2c_pkg::HPROD_W'(ep2c_pkg::HOUR_RECIP);
        item_next.rem_day = rem_day_reg;
        item_next.micro   = micro2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
        end else begin
            if (en1) begin
                f1_v_reg <= s_valid;
            end
            if (en2) begin
                f2_v_reg <= f1_v_reg;
            end
            if (en3) begin
                f3_v_reg <= f2_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            x_reg        <= secs_in[ep2c_pkg::SECS_W-1:ep2c_pkg::LOW_W];
            low_reg      <= secs_in[ep2c_pkg::LOW_W-1:0];
            day_prod_reg <= day_prod_next;
            yr_prod_reg  <= yr_prod_next;
            micro1_reg   <= micro_in;
        end
        if (en2) begin
            days_reg    <= days_next;
            rem_day_reg <= rem_day_next;
            k_reg       <= k_next;
            micro2_reg  <= micro1_reg;
        end
        if (en3) begin
            item_reg <= item_next;
        end
    end

endmodule

### hdl/ep2c_fifo.sv
// ----------------------------------------------------------------------------
// ep2c_fifo: short queue between the front and back ends
// Circular buffer with a fill count; the head entry is read directly.
// ----------------------------------------------------------------------------
module ep2c_fifo #(
    parameter int DEPTH = ep2c_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ep2c_pkg::q_ctrl_t q_ctrl,
    input  ep2c_pkg::split_t  wr_item,
    output ep2c_pkg::q_stat_t q_stat,
    output ep2c_pkg::split_t  rd_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ep2c_pkg::split_t mem_reg [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign q_stat.can_push = (count_reg != CW'(DEPTH));
    assign q_stat.can_pop  = (count_reg != '0);
    assign rd_item         = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_ctrl.push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (q_ctrl.pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (q_ctrl.push && !q_ctrl.pop) begin
            count_next = count_reg + CW'(1);
        end else if (q_ctrl.pop && !q_ctrl.push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_ctrl.push) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

### hdl/ep2c_back.sv
// ----------------------------------------------------------------------------
// ep2c_back: resolves year, month and day, finishes the time of day
// Three stages; the last one is the output register.
// ----------------------------------------------------------------------------
module ep2c_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  ep2c_pkg::q_stat_t q_stat,
    input  ep2c_pkg::split_t  in_item,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output ep2c_pkg::result_t out_item
);

    logic b1_v_reg, b2_v_reg, b3_v_reg;
    logic en1, en2, en3;

    // Stage 1 registers
    logic [ep2c_pkg::YEAR_W-1:0]  y1_reg, y1_next;
    logic [ep2c_pkg::DOY_W-1:0]   dn1_reg, dn1_next;
    logic                         leap1_reg, leap1_next;
    logic [ep2c_pkg::HOUR_W-1:0]  hr1_reg, hr1_next;
    logic [ep2c_pkg::REM2_W-1:0]  rem2_1_reg, rem2_1_next;
    logic [ep2c_pkg::MICRO_W-1:0] micro1_reg;

    // Stage 2 registers
    logic [ep2c_pkg::YEAR_W-1:0]  y2_reg;
    logic [ep2c_pkg::DOY_W-1:0]   dn2_reg;
    logic                         leap2_reg;
    logic [ep2c_pkg::MONTH_W-1:0] mon2_reg, mon2_next;
    logic [ep2c_pkg::HOUR_W-1:0]  hr2_reg;
    logic [ep2c_pkg::MPROD_W-1:0] m_prod_reg, m_prod_next;
    logic [ep2c_pkg::REM2_W-1:0]  rem2_2_reg;
    logic [ep2c_pkg::MICRO_W-1:0] micro2_reg;

    ep2c_pkg::result_t            out_reg, out_next;

    logic                         corr;
    logic [ep2c_pkg::DN_W-1:0]    dn_fix;
    logic [ep2c_pkg::HR_W-1:0]    hr_r;
    logic [ep2c_pkg::HOUR_W-1:0]  hq;
    logic [ep2c_pkg::DOY_W-1:0]   thr;
    logic [ep2c_pkg::MINUTE_W-1:0] mq;
    logic [ep2c_pkg::MX_W-1:0]    mr_wide;
    logic [ep2c_pkg::MR_W-1:0]    mr;
    logic [ep2c_pkg::MONTH_W-1:0] mon_idx;
    logic [ep2c_pkg::DOY_W-1:0]   dom_wide;

    assign en3       = !b3_v_reg || out_ready;
    assign en2       = !b2_v_reg || en3;
    assign en1       = !b1_v_reg || en2;
    assign pop       = q_stat.can_pop && en1;
    assign out_valid = b3_v_reg;
    assign out_item  = out_reg;

    // Stage 1: correct the year once if the day of year came out not positive
    always_comb begin
        corr = in_item.dn0[ep2c_pkg::DN_W-1] || (in_item.dn0 == '0);
        dn_fix = in_item.dn0 + ep2c_pkg::DN_W'(ep2c_pkg::DAYS_PER_YEAR)
               + ep2c_pkg::DN_W'(in_item.k[1:0] == 2'b11);
        if (corr) begin
            y1_next  = ep2c_pkg::YEAR_W'(in_item.k)
                     + ep2c_pkg::YEAR_W'(ep2c_pkg::LEAP_BASE_YEAR);
            dn1_next = dn_fix[ep2c_pkg::DOY_W-1:0];
        end else begin
            y1_next  = ep2c_pkg::YEAR_W'(in_item.k) + ep2c_pkg::YEAR_W'(ep2c_pkg::BASE_YEAR);
            dn1_next = in_item.dn0[ep2c_pkg::DOY_W-1:0];
        end
        // Only 2000 and 2100 are century years in reach; 2000 is a leap year
        leap1_next = (y1_next[1:0] == 2'b00)
                  && (y1_next != ep2c_pkg::YEAR_W'(ep2c_pkg::SKIPPED_LEAP_YR));

        hq   = in_item.h_prod[ep2c_pkg::HOUR_SHIFT +: ep2c_pkg::HOUR_W];
        hr_r = ep2c_pkg::HR_W'(ep2c_pkg::HX_W'(in_item.rem_day[ep2c_pkg::REM_W-1:4])
             - ep2c_pkg::HX_W'(hq) * ep2c_pkg::HX_W'(ep2c_pkg::HOUR_DIV));
        if (hr_r >= ep2c_pkg::HR_W'(ep2c_pkg::HOUR_DIV)) begin
            hr1_next = hq + 5'd1;
            hr_r     = hr_r - ep2c_pkg::HR_W'(ep2c_pkg::HOUR_DIV);
        end else begin
            hr1_next = hq;
        end
        rem2_1_next = {hr_r[7:0], in_item.rem_day[3:0]};
    end

    // Stage 2: month from the start table, minute product
    always_comb begin
        mon2_next = 4'd1;
        thr       = '0;
        for (int i = 1; i < ep2c_pkg::MONTHS; i++) begin
            thr = ep2c_pkg::month_start(ep2c_pkg::MONTH_W'(i))
                + ep2c_pkg::DOY_W'((i >= 2) && leap1_reg);
            if (dn1_reg > thr) begin
                mon2_next = ep2c_pkg::MONTH_W'(i + 1);
            end
        end
        m_prod_next = ep2c_pkg::MPROD_W'(rem2_1_reg[ep2c_pkg::REM2_W-1:2])
                    * ep2c_pkg::MPROD_W'(ep2c_pkg::MIN_RECIP);
    end

    // Stage 3: day of month, minute and second
    always_comb begin
        mon_idx  = mon2_reg - 4'd1;
        dom_wide = dn2_reg - ep2c_pkg::month_start(mon_idx)
                 - ep2c_pkg::DOY_W'((mon2_reg >= 4'd3) && leap2_reg);

        mq      = m_prod_reg[ep2c_pkg::MIN_SHIFT +: ep2c_pkg::MINUTE_W];
        mr_wide = rem2_2_reg[ep2c_pkg::REM2_W-1:2]
                - ep2c_pkg::MX_W'(mq) * ep2c_pkg::MX_W'(ep2c_pkg::MIN_DIV);
        mr      = mr_wide[ep2c_pkg::MR_W-1:0];
        if (mr >= ep2c_pkg::MR_W'(ep2c_pkg::MIN_DIV)) begin
            out_next.minute = mq + 6'd1;
            mr              = mr - ep2c_pkg::MR_W'(ep2c_pkg::MIN_DIV);
        end else begin
            out_next.minute = mq;
        end
        out_next.second = {mr[3:0], rem2_2_reg[1:0]};
        out_next.year   = y2_reg;
        out_next.month  = mon2_reg;
        out_next.dom    = dom_wide[ep2c_pkg::DOM_W-1:0];
        out_next.hour   = hr2_reg;
        out_next.micro  = micro2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_v_reg <= 1'b0;
            b2_v_reg <= 1'b0;
            b3_v_reg <= 1'b0;
        end else begin
            if (en1) begin
                b1_v_reg <= q_stat.can_pop;
            end
            if (en2) begin
                b2_v_reg <= b1_v_reg;
            end
            if (en3) begin
                b3_v_reg <= b2_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            y1_reg     <= y1_next;
            dn1_reg    <= dn1_next;
            leap1_reg  <= leap1_next;
            hr1_reg    <= hr1_next;
            rem2_1_reg <= rem2_1_next;
            micro1_reg <= in_item.micro;
        end
        if (en2) begin
            y2_reg     <= y1_reg;
            dn2_reg    <= dn1_reg;
            leap2_reg  <= leap1_reg;
            mon2_reg   <= mon2_next;
            hr2_reg    <= hr1_reg;
            m_prod_reg <= m_prod_next;
            rem2_2_reg <= rem2_1_reg;
            micro2_reg <= micro1_reg;
        end
        if (en3) begin
            out_reg <= out_next;
        end
    end

endmodule

### hdl/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: seconds since 1970 to calendar date and time
// Path: an accepted item passes three front stages, the queue and three
// back stages before its result is shown.
// Throughput: one item per cycle while neither side stalls, set by the fully
// pipelined constant dividers; each side stalls on its own behind the queue.
// Reset: aresetn low at a clock edge empties every stage and the queue.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar #(
    parameter int FIFO_DEPTH = ep2c_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [31:0] epoch_seconds, [51:32] micro_in, [55:52] zero
    input  logic [ep2c_pkg::S_TDATA_W-1:0]   s_tdata,

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [11:0] year, [15:12] month, [20:16] day_of_month, [25:21] hour,
    // [31:26] minute, [37:32] second, [57:38] microsecond, [63:58] zero
    output logic [ep2c_pkg::M_TDATA_W-1:0]   m_tdata
);

    // The front end divides the seconds count into a day number and the
    // seconds within that day, and estimates the year from 365-day years.
    // Both divisions are done by multiplying with a scaled reciprocal; the
    // quotient can be one short, which a single compare and subtract puts
    // right. Its last stage forms the hour product and the first estimate
    // of the day within the year.
    //
    // The back end lowers the year once when that estimate is not
    // positive, picks the month from the month start table (shifted by a
    // day from March on in leap years, so that February the 29th comes out
    // as such), and finishes hour, minute and second. Its last stage is the
    // output register; a waiting result stalls it, but earlier stages take new items until full.

    ep2c_pkg::q_stat_t q_stat;
    ep2c_pkg::q_ctrl_t q_ctrl;
    ep2c_pkg::split_t  front_item;
    ep2c_pkg::split_t  queue_item;
    ep2c_pkg::result_t result;
    logic              push;
    logic              pop;

    assign q_ctrl.push = push;
    assign q_ctrl.pop  = pop;

    ep2c_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .secs_in  (s_tdata[ep2c_pkg::SECS_W-1:0]),
        .micro_in (s_tdata[ep2c_pkg::SECS_W +: ep2c_pkg::MICRO_W]),
        .q_stat   (q_stat),
        .push     (push),
        .item     (front_item)
    );

    ep2c_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_ctrl  (q_ctrl),
        .wr_item (front_item),
        .q_stat  (q_stat),
        .rd_item (queue_item)
    );

    ep2c_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_stat    (q_stat),
        .in_item   (queue_item),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (result)
    );

    // Fields packed from the lowest bit up, padded with zeros to 64 bits
    assign m_tdata = {6'd0, result.micro, result.second, result.minute,
                      result.hour, result.dom, result.month, result.year};

endmodule

### hdl/ep2c_checker.sv
// ----------------------------------------------------------------------------
// ep2c_checker: port level checks for the epoch seconds converter
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module ep2c_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ep2c_pkg::M_TDATA_W-1:0] m_tdata
);

    // A result that is not taken stays offered and unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or withdrawn while stalled");

    // Month, hour, minute and second stay within their ranges for any input.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:12] >= 4'd1) && (m_tdata[15:12] <= 4'd12)
                  && (m_tdata[25:21] <= 5'd23) && (m_tdata[31:26] <= 6'd59)
                  && (m_tdata[37:32] <= 6'd59))
        else $error("time or month field out of range");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered straight after reset");

endmodule

bind epoch_seconds_to_calendar ep2c_checker u_ep2c_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the epoch seconds to calendar converter
// Timestamps go in on the input stream and each is turned into the calendar
// date and time that the converter should give. Those dates wait in order
// and are compared field by field with the items that come out. The input
// side sends in bursts of random length and the output side stalls on a
// changing pattern, so back pressure reaches every pipeline stage.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned SECS_PER_DAY      = 32'd86400;
    localparam int unsigned SECS_PER_HOUR     = 32'd3600;
    localparam int unsigned SECS_PER_MIN      = 32'd60;
    localparam int unsigned SECS_PER_365_YEAR = 32'd31536000;
    localparam int unsigned VALID_LAST_SEC    = 32'd4102444799;    // 2099-12-31 23:59:59
    localparam int unsigned MICRO_LAST        = 32'd999999;
    localparam int          EPOCH_YEAR        = 1970;
    localparam int          LEAP_COUNT_BASE   = 1969;
    localparam int          RANDOM_STAMPS     = 500;
    localparam int          DRAIN_CYCLES      = 16;
    localparam int          REPORT_LIMIT      = 10;
    localparam int          RUN_LIMIT_NS      = 400000;

    // Directed timestamps: the ends of the field ranges, leap days, the year
    // estimate that has to be pulled back by one, and dates past 2099.
    localparam int EDGE_COUNT = 16;
    localparam logic [31:0] EDGE_SECS [EDGE_COUNT] = '{
        32'd0,              // epoch itself
        32'd31535999,       // last second of 1970
        32'd68169600,       // 1972-02-29, first leap day
        32'd68255999,       // 1972-02-29 23:59:59, last second of the leap day
        32'd94694399,       // 1972-12-31 23:59:59, year estimate one too high
        32'd94694400,       // 1973-01-01
        32'd946684799,      // 1999-12-31 23:59:59
        32'd951782400,      // 2000-02-29, century leap year
        32'd951868800,      // 2000-03-01
        32'd1709210096,     // 2024-02-29 12:34:56
        32'd1234567890,
        32'd4102358400,     // 2099-12-31 00:00:00
        32'd4102444799,     // last valid second
        32'd4102444800,     // 2100-01-01, outside the valid range
        32'd4107542400,     // 2100-03-01, no leap day in 2100
        32'hFFFF_FFFF       // every seconds bit set
    };
    localparam logic [19:0] EDGE_MICRO [EDGE_COUNT] = '{
        20'd0, 20'd999999, 20'd1, 20'h55555, 20'hAAAAA, 20'd0, 20'd999999, 20'd500000,
        20'd123456, 20'hFFFFF, 20'd0, 20'd999998, 20'd999999, 20'hF4240, 20'd7, 20'hFFFFF
    };

    typedef struct {
        logic [31:0]       secs;
        ep2c_pkg::result_t date;
    } dated_stamp_t;

    // Holds the dates still owed by the converter and checks each one as it
    // comes out.
    class calendar_scoreboard;
        dated_stamp_t awaited[$];
        int first_day [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
        int failures = 0;

        function int day_of_year(int days, int yr);
            return days - 365 * (yr - EPOCH_YEAR) - (yr - LEAP_COUNT_BASE) / 4 + 1;
        endfunction

        function ep2c_pkg::result_t calendar_of(logic [31:0] secs, logic [19:0] micro);
            int unsigned s;
            int days, yr, doy, leap, mon, dom;
            ep2c_pkg::result_t r;
            s    = secs;
            days = int'(s / SECS_PER_DAY);
            // Estimate from 365-day years, then pull back once if the leap
            // days already passed put the day before the start of that year.
            yr  = int'(s / SECS_PER_365_YEAR) + EPOCH_YEAR;
            doy = day_of_year(days, yr);
            if (doy <= 0) begin
                yr--;
                doy = day_of_year(days, yr);
            end
            leap = (((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0)) ? 1 : 0;
            mon  = 1;
            for (int i = 0; i < 12; i++) begin
                if (doy > first_day[i] + (i >= 2 ? leap : 0))
                    mon = i + 1;
            end
            dom = doy - first_day[mon - 1] - (mon >= 3 ? leap : 0);
            r.year   = yr[11:0];
            r.month  = mon[3:0];
            r.dom    = dom[4:0];
            r.hour   = 5'((s % SECS_PER_DAY) / SECS_PER_HOUR);
            r.minute = 6'((s % SECS_PER_HOUR) / SECS_PER_MIN);
            r.second = 6'(s % SECS_PER_MIN);
            r.micro  = micro;
            return r;
        endfunction

        function void note_stamp(logic [31:0] secs, logic [19:0] micro);
            dated_stamp_t entry;
            entry.secs = secs;
            entry.date = calendar_of(secs, micro);
            awaited.push_back(entry);
        endfunction

        function void check_date(logic [63:0] beat);
            dated_stamp_t      want;
            ep2c_pkg::result_t got;
            got.year   = beat[11:0];
            got.month  = beat[15:12];
            got.dom    = beat[20:16];
            got.hour   = beat[25:21];
            got.minute = beat[31:26];
            got.second = beat[37:32];
            got.micro  = beat[57:38];
            if (awaited.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("%0t: date item %h arrived with no timestamp outstanding",
                             $realtime, beat);
                return;
            end
            want = awaited.pop_front();
            if (got.year !== want.date.year || got.month !== want.date.month ||
                got.dom !== want.date.dom || got.hour !== want.date.hour ||
                got.minute !== want.date.minute || got.second !== want.date.second ||
                got.micro !== want.date.micro || beat[63:58] !== 6'd0) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("%0t: date mismatch for %0d s: expected %0d-%0d-%0d %0d:%0d:%0d.%0d",
                             $realtime, want.secs,
                             want.date.year, want.date.month, want.date.dom,
                             want.date.hour, want.date.minute, want.date.second,
                             want.date.micro);
                    $display("    got %0d-%0d-%0d %0d:%0d:%0d.%0d pad %h",
                             got.year, got.month, got.dom, got.hour, got.minute,
                             got.second, got.micro, beat[63:58]);
                end
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;

    calendar_scoreboard ledger = new();
    int burst_left = 0;

    epoch_seconds_to_calendar DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Seconds from the epoch to 1 January of a year.
    function automatic longint jan1_seconds(int yr);
        longint days = 0;
        for (int y = EPOCH_YEAR; y < yr; y++)
            days += (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 366 : 365;
        return days * SECS_PER_DAY;
    endfunction

    // Offers one item and returns at the falling edge after it is taken. A
    // gap with s_tvalid low opens between bursts, and now and then a long burst
    // keeps the input busy without a break.
    task automatic send_stamp(input logic [31:0] secs, input logic [19:0] micro);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, micro, secs};
        do @(posedge aclk); while (!s_tready);
        ledger.note_stamp(secs, micro);
        @(negedge aclk);
    endtask

    // The output side changes its manner from one phase to the next: always
    // ready, ready at random, mostly ready, or long stalls.
    initial begin : result_sink
        int phase_left = 0;
        int manner     = 0;
        int stall_left = 0;
        forever begin
            @(negedge aclk);
            if (phase_left == 0) begin
                manner     = $urandom_range(0, 3);
                phase_left = $urandom_range(20, 80);
            end
            phase_left--;
            case (manner)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) != 0);
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        m_tready <= 1'b0;
                    end else if ($urandom_range(0, 3) == 0) begin
                        stall_left = $urandom_range(1, 12);
                        m_tready <= 1'b0;
                    end else begin
                        m_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            ledger.check_date(m_tdata);
    end

    initial begin : stimulus
        int          kind;
        int          yr;
        longint      near;
        logic [31:0] stamp;
        logic [19:0] micro;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < EDGE_COUNT; i++)
            send_stamp(EDGE_SECS[i], EDGE_MICRO[i]);

        // Mostly valid dates, with extra weight near new year and near the
        // end of February in every fourth year from 1972, and some full-range seconds.
        for (int i = 0; i < RANDOM_STAMPS; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                stamp = $urandom_range(0, VALID_LAST_SEC);
            end else if (kind < 75) begin
                yr   = $urandom_range(EPOCH_YEAR, 2100);
                near = jan1_seconds(yr) + longint'($urandom_range(0, 4 * SECS_PER_DAY))
                       - 2 * longint'(SECS_PER_DAY);
                if (near < 0)
                    near = 0;
                stamp = near[31:0];
            end else if (kind < 90) begin
                yr    = 1972 + 4 * $urandom_range(0, 32);
                near  = jan1_seconds(yr) + 58 * longint'(SECS_PER_DAY)
                        + longint'($urandom_range(0, 3 * SECS_PER_DAY - 1));
                stamp = near[31:0];
            end else begin
                stamp = $urandom();
            end
            micro = ($urandom_range(0, 4) == 0) ? 20'($urandom())
                                                : 20'($urandom_range(0, MICRO_LAST));
            send_stamp(stamp, micro);
        end
        s_tvalid <= 1'b0;

        while (ledger.awaited.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (ledger.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### files.f
hdl/ep2c_pkg.sv
hdl/ep2c_front.sv
hdl/ep2c_fifo.sv
hdl/ep2c_back.sv
hdl/epoch_seconds_to_calendar.sv
hdl/ep2c_checker.sv
tb/tb.sv
